>>> design/jacobi_poisson_1d_sweeps_top_defines.svh
// Assertion macros shared by the Jacobi sweep block.
`ifndef JACOBI_POISSON_1D_SWEEPS_TOP_DEFINES_SVH
`define JACOBI_POISSON_1D_SWEEPS_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define JPS_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("Jacobi sweep block: same-cycle check failed.");

// The condition must hold in the cycle after the trigger.
`define JPS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("Jacobi sweep block: next-cycle check failed.");

`endif

>>> design/jps_pkg.sv
// Types and constants of the Jacobi sweep block.
`default_nettype none
package jps_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 11;
  localparam int SWEEP_W   = 16;
  localparam int REQ_W     = 2;
  localparam int REG_IDX_W = 2;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_INTERVAL_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SWEEP_COUNT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_SQUARED   = 2'd2;

  localparam logic [IDX_W-1:0]   INTERVAL_COUNT_RESET = 11'd100;
  localparam logic [SWEEP_W-1:0] SWEEP_COUNT_RESET    = 16'd100;
  localparam logic [DATA_W-1:0]  STEP_SQUARED_RESET   = 32'd429497;

  localparam int MIN_RUN_INTERVALS = 2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [IDX_W-1:0]         point_index;
    logic signed [DATA_W-1:0] solution_in;
    logic signed [DATA_W-1:0] source_in;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] solution_out;
    logic                     status;
  } resp_t;

  typedef struct packed {
    logic u_re;
    logic scr_re;
    logic src_re;
  } rd_en_t;

  typedef struct packed {
    logic u_we;
    logic scr_we;
  } wr_en_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

endpackage
`default_nettype wire

>>> design/jacobi_poisson_1d_sweeps_top.sv
// Top level of the 1D Poisson Jacobi solver: request handling, point stores and output stage.
`default_nettype none
`include "jacobi_poisson_1d_sweeps_top_defines.svh"
// Point writes and reads are taken one transaction per clock unless req_stall holds them; a
// read answer passes the pending slot, then the output register, once accepted. A run walks
// the solution or scratch store and the source store each half-sweep, one point per cycle
// through a single read port of each memory, for 2 * ceil(sweep_count / 2) half-sweeps, and
// no transaction is accepted while it is in progress. Points must be written before a run or
// a read touches them; the stores are not cleared at reset.
module jacobi_poisson_1d_sweeps_top import jps_pkg::*; #(
  parameter int MAX_INTERVALS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  req,
  input  logic                  req_valid,
  output logic                  req_stall,
  output resp_t                 resp,
  output logic                  resp_valid,
  input  logic                  resp_stall,
  input  logic                  cfg_wen,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_INTERVALS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_INTERVALS);

  logic [IDX_W-1:0]   interval_count;
  logic [SWEEP_W-1:0] sweep_count;
  logic [DATA_W-1:0]  step_squared;

  logic               pend_valid;
  logic               pend_read;
  logic               pend_status;

  logic               req_acc;
  logic               pend_move;
  logic               pend_load;
  logic               load_read;
  logic               load_status;
  logic               is_write;
  logic               is_run;
  logic               is_read;
  logic [LW-1:0]      icount_l;
  logic [LW-1:0]      limit;
  logic               idx_bad;
  logic               run_big;
  logic               run_go;
  logic [SWEEP_W-1:0] passes;
  logic [AW-1:0]      idx_addr;

  rd_en_t             sw_rd;
  wr_en_t             sw_wr;
  sweep_stat_t        sw_stat;
  logic [AW-1:0]      sw_rd_addr;
  logic [AW-1:0]      sw_src_addr;
  logic [AW-1:0]      sw_waddr;
  logic signed [DATA_W-1:0] sw_wdata;

  logic               u_we;
  logic [AW-1:0]      u_waddr;
  logic [DATA_W-1:0]  u_wdata;
  logic               u_re;
  logic [AW-1:0]      u_raddr;
  logic [DATA_W-1:0]  u_rdata;
  logic               src_we;
  logic [DATA_W-1:0]  src_rdata;
  logic [DATA_W-1:0]  scr_rdata;

  always_comb begin
    is_write  = (req.req_type == REQ_WRITE);
    is_run    = (req.req_type == REQ_RUN);
    is_read   = (req.req_type == REQ_READ);
    icount_l  = LW'(interval_count);
    limit     = (icount_l > MAX_L) ? MAX_L : icount_l;
    idx_bad   = LW'(req.point_index) > limit;
    idx_addr  = AW'(req.point_index);
    run_big   = icount_l > MAX_L;
    run_go    = is_run && !run_big && (icount_l >= LW'(MIN_RUN_INTERVALS))
                && (sweep_count != '0);
    passes    = SWEEP_W'(({1'b0, sweep_count} + (SWEEP_W + 1)'(1)) >> 1);

    pend_move = pend_valid && (!resp_valid || !resp_stall);
    req_stall = sw_stat.busy || (pend_valid && !pend_move);
    req_acc   = req_valid && !req_stall;

    pend_load   = (req_acc && !run_go) || sw_stat.done;
    load_read   = req_acc && is_read && !idx_bad;
    load_status = req_acc && (((is_write || is_read) && idx_bad) || (is_run && run_big));

    u_we    = (req_acc && is_write && !idx_bad) || sw_wr.u_we;
    u_waddr = sw_wr.u_we ? sw_waddr : idx_addr;
    u_wdata = sw_wr.u_we ? sw_wdata : req.solution_in;
    u_re    = load_read || sw_rd.u_re;
    u_raddr = sw_rd.u_re ? sw_rd_addr : idx_addr;
    src_we  = req_acc && is_write && !idx_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_count <= INTERVAL_COUNT_RESET;
      sweep_count    <= SWEEP_COUNT_RESET;
      step_squared   <= STEP_SQUARED_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_INTERVAL_COUNT: interval_count <= cfg_data[IDX_W-1:0];
        REG_SWEEP_COUNT:    sweep_count    <= cfg_data[SWEEP_W-1:0];
        REG_STEP_SQUARED:   step_squared   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      resp_valid <= 1'b0;
    end else begin
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        resp_valid <= 1'b1;
      end else if (!resp_stall) begin
        resp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_read   <= load_read;
      pend_status <= load_status;
    end
    if (pend_move) begin
      resp.solution_out <= pend_read ? u_rdata : '0;
      resp.status       <= pend_status;
    end
  end

  jps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_solution_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .re    (u_re),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  jps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_source_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (idx_addr),
    .wdata (req.source_in),
    .re    (sw_rd.src_re),
    .raddr (sw_src_addr),
    .rdata (src_rdata)
  );

  jps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_scratch_ram (
    .clk   (clk),
    .we    (sw_wr.scr_we),
    .waddr (sw_waddr),
    .wdata (sw_wdata),
    .re    (sw_rd.scr_re),
    .raddr (sw_rd_addr),
    .rdata (scr_rdata)
  );

  jps_sweep #(.AW(AW), .NW(LW)) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .start     (req_acc && run_go),
    .n         (icount_l),
    .passes    (passes),
    .h2        (step_squared),
    .resp_free (!pend_valid || pend_move),
    .u_rdata   (u_rdata),
    .scr_rdata (scr_rdata),
    .src_rdata (src_rdata),
    .rd_en     (sw_rd),
    .rd_addr   (sw_rd_addr),
    .src_addr  (sw_src_addr),
    .wr_en     (sw_wr),
    .wr_addr   (sw_waddr),
    .wr_data   (sw_wdata),
    .stat      (sw_stat)
  );

  `JPS_ASSERT_SAME(a_done_slot_free, sw_stat.done, !pend_valid || pend_move)
  `JPS_ASSERT_NEXT(a_run_starts, req_acc && run_go, sw_stat.busy)
  `JPS_ASSERT_SAME(a_no_write_clash, sw_wr.u_we || sw_wr.scr_we, !req_acc)
  `JPS_ASSERT_NEXT(a_zero_unless_read, pend_move && !pend_read, resp.solution_out == '0)

endmodule
`default_nettype wire

>>> design/jps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module jps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/jps_relax.sv
// Relaxation datapath: registered h2*f product, then halved saturating three-term sum.
`default_nettype none
module jps_relax import jps_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] src,
  input  logic [DATA_W-1:0]        h2,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] result
);

  logic signed [2*DATA_W:0]   prod;
  logic signed [DATA_W-1:0]   term;
  logic signed [DATA_W-1:0]   left_q;
  logic signed [DATA_W-1:0]   right_q;
  logic signed [DATA_W+1:0]   sum;
  logic signed [DATA_W:0]     halved;

  assign prod = src * $signed({1'b0, h2});

  always_ff @(posedge clk) begin
    if (load) begin
      term    <= prod[2*DATA_W-1:DATA_W];
      left_q  <= left;
      right_q <= right;
    end
  end

  always_comb begin
    sum = {{2{left_q[DATA_W-1]}}, left_q} + {{2{right_q[DATA_W-1]}}, right_q}
        + {{2{term[DATA_W-1]}}, term};
    halved = sum[DATA_W+1:1];
    if (halved[DATA_W] != halved[DATA_W-1]) begin
      result = halved[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      result = halved[DATA_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> design/jps_sweep.sv
// Sweep sequencer: streams each store through a sliding window and writes relaxed points back.
`default_nettype none
module jps_sweep import jps_pkg::*; #(
  parameter int AW = 11,
  parameter int NW = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NW-1:0]            n,
  input  logic [SWEEP_W-1:0]       passes,
  input  logic [DATA_W-1:0]        h2,
  input  logic                     resp_free,
  input  logic signed [DATA_W-1:0] u_rdata,
  input  logic signed [DATA_W-1:0] scr_rdata,
  input  logic signed [DATA_W-1:0] src_rdata,
  output rd_en_t                   rd_en,
  output logic [AW-1:0]            rd_addr,
  output logic [AW-1:0]            src_addr,
  output wr_en_t                   wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic signed [DATA_W-1:0] wr_data,
  output sweep_stat_t              stat
);

  localparam int JW = NW + 1;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DRAIN, S_FINISH} state_t;

  state_t               state;
  logic [JW-1:0]        j;
  logic                 half;
  logic [SWEEP_W-1:0]   pass_left;
  logic                 drain_cnt;
  logic [NW-1:0]        n_reg;

  logic                 d1_valid;
  logic [JW-1:0]        d1_j;
  logic                 d1_half;

  logic                 d2_valid;
  logic                 d2_copy;
  logic                 d2_half;
  logic [AW-1:0]        d2_addr;
  logic signed [DATA_W-1:0] d2_copyval;

  logic signed [DATA_W-1:0] win1;
  logic signed [DATA_W-1:0] win2;

  logic [JW-1:0]        n_ext;
  logic [JW-1:0]        n_p1;
  logic                 issue;
  logic                 issue_rd;
  logic                 last_issue;
  logic signed [DATA_W-1:0] data;
  logic                 d1_in_range;
  logic                 relax_load;
  logic                 copy_first;
  logic                 copy_last;
  logic signed [DATA_W-1:0] relax_result;

  always_comb begin
    n_ext       = JW'(n_reg);
    n_p1        = n_ext + JW'(1);
    issue       = (state == S_SWEEP);
    issue_rd    = issue && (j <= n_ext);
    last_issue  = issue && (j == n_p1);
    rd_en.u_re   = issue_rd && !half;
    rd_en.scr_re = issue_rd && half;
    rd_en.src_re = issue;
    rd_addr     = AW'(j);
    src_addr    = (j == '0) ? '0 : AW'(j - JW'(1));

    data        = d1_half ? scr_rdata : u_rdata;
    d1_in_range = d1_valid && (d1_j <= n_ext);
    relax_load  = d1_in_range && (d1_j >= JW'(2));
    copy_first  = d1_valid && (d1_j == '0);
    copy_last   = d1_valid && (d1_j == n_p1);

    wr_en.u_we   = d2_valid && d2_half;
    wr_en.scr_we = d2_valid && !d2_half;
    wr_addr      = d2_addr;
    wr_data      = d2_copy ? d2_copyval : relax_result;

    stat.busy = (state != S_IDLE);
    stat.done = (state == S_FINISH) && resp_free;
  end

  jps_relax u_relax (
    .clk    (clk),
    .load   (relax_load),
    .src    (src_rdata),
    .h2     (h2),
    .left   (win2),
    .right  (data),
    .result (relax_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      j         <= '0;
      half      <= 1'b0;
      pass_left <= '0;
      drain_cnt <= 1'b0;
      d1_valid  <= 1'b0;
      d2_valid  <= 1'b0;
    end else begin
      d1_valid <= issue;
      d2_valid <= relax_load || copy_first || copy_last;
      case (state)
        S_IDLE: begin
          if (start) begin
            state     <= S_SWEEP;
            j         <= '0;
            half      <= 1'b0;
            pass_left <= passes;
          end
        end
        S_SWEEP: begin
          j <= j + JW'(1);
          if (last_issue) begin
            state     <= S_DRAIN;
            drain_cnt <= 1'b0;
          end
        end
        S_DRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            j <= '0;
            if (!half) begin
              half  <= 1'b1;
              state <= S_SWEEP;
            end else if (pass_left > SWEEP_W'(1)) begin
              half      <= 1'b0;
              pass_left <= pass_left - SWEEP_W'(1);
              state     <= S_SWEEP;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (resp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) begin
      n_reg <= n;
    end
    d1_j    <= j;
    d1_half <= half;
    d2_half <= d1_half;
    d2_copy <= copy_first || copy_last;
    if (copy_first) begin
      d2_addr    <= '0;
      d2_copyval <= data;
    end else if (copy_last) begin
      d2_addr    <= AW'(n_reg);
      d2_copyval <= win1;
    end else begin
      d2_addr    <= AW'(d1_j - JW'(1));
      d2_copyval <= data;
    end
    if (d1_in_range) begin
      win2 <= win1;
      win1 <= data;
    end
  end

endmodule
`default_nettype wire

>>> test/jacobi_sweep_checker.sv
// Checker for the Jacobi sweep block: predicts every answer and compares it with the block.
`timescale 1ns / 100ps
module jacobi_sweep_checker import jps_pkg::*; #(
  parameter int MAX_INTERVALS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  resp_t                resp,
  input  logic                 resp_valid,
  input  logic                 resp_stall,
  input  logic                 cfg_wen,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   error_count,
  output int                   pending_count
);

  localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO = 64'shFFFF_FFFF_8000_0000;

  logic [IDX_W-1:0]         mesh_intervals;
  logic [SWEEP_W-1:0]       sweeps_requested;
  logic [DATA_W-1:0]        step_sq;
  logic signed [DATA_W-1:0] u_mem [0:MAX_INTERVALS];
  logic signed [DATA_W-1:0] f_mem [0:MAX_INTERVALS];
  logic signed [DATA_W-1:0] scratch_mem [0:MAX_INTERVALS];
  resp_t                    expected_answers [$];

  initial begin
    for (int i = 0; i <= MAX_INTERVALS; i++) begin
      u_mem[i] = '0;
      f_mem[i] = '0;
      scratch_mem[i] = '0;
    end
  end

  // One Jacobi update: (left + right + h2*f / 2^32) / 2 with floored shifts and saturation.
  function automatic logic signed [DATA_W-1:0] relax_point(
    input logic signed [DATA_W-1:0] left,
    input logic signed [DATA_W-1:0] right,
    input logic signed [DATA_W-1:0] src,
    input logic [DATA_W-1:0]        h2
  );
    longint prod;
    longint sum;
    prod = longint'({{32{src[DATA_W-1]}}, src}) * longint'({32'd0, h2});
    sum = longint'(left) + longint'(right) + (prod >>> 32);
    sum = sum >>> 1;
    if (sum > SAT_HI) return 32'sh7FFF_FFFF;
    if (sum < SAT_LO) return 32'sh8000_0000;
    return sum[DATA_W-1:0];
  endfunction

  function automatic void run_jacobi(input int n);
    int passes;
    passes = (int'(sweeps_requested) + 1) / 2;
    scratch_mem[0] = u_mem[0];
    scratch_mem[n] = u_mem[n];
    for (int p = 0; p < passes; p++) begin
      for (int i = 1; i < n; i++) begin
        scratch_mem[i] = relax_point(u_mem[i-1], u_mem[i+1], f_mem[i], step_sq);
      end
      for (int i = 1; i < n; i++) begin
        u_mem[i] = relax_point(scratch_mem[i-1], scratch_mem[i+1], f_mem[i], step_sq);
      end
    end
  endfunction

  function automatic resp_t answer_request(input req_t r);
    resp_t a;
    int limit;
    a = '0;
    limit = (mesh_intervals > MAX_INTERVALS) ? MAX_INTERVALS : int'(mesh_intervals);
    case (r.req_type)
      REQ_WRITE: begin
        if (int'(r.point_index) > limit) begin
          a.status = 1'b1;
        end else begin
          u_mem[r.point_index] = r.solution_in;
          f_mem[r.point_index] = r.source_in;
        end
      end
      REQ_RUN: begin
        if (mesh_intervals > MAX_INTERVALS) begin
          a.status = 1'b1;
        end else if (mesh_intervals >= MIN_RUN_INTERVALS) begin
          run_jacobi(int'(mesh_intervals));
        end
      end
      REQ_READ: begin
        if (int'(r.point_index) > limit) begin
          a.status = 1'b1;
        end else begin
          a.solution_out = u_mem[r.point_index];
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    resp_t want;
    if (rst) begin
      mesh_intervals = INTERVAL_COUNT_RESET;
      sweeps_requested = SWEEP_COUNT_RESET;
      step_sq = STEP_SQUARED_RESET;
      expected_answers.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_INTERVAL_COUNT: mesh_intervals = cfg_data[IDX_W-1:0];
          REG_SWEEP_COUNT:    sweeps_requested = cfg_data[SWEEP_W-1:0];
          REG_STEP_SQUARED:   step_sq = cfg_data;
          default: begin
          end
        endcase
      end
      if (resp_valid && !resp_stall) begin
        if (expected_answers.size() == 0) begin
          error_count++;
          $error("Answer with no request outstanding: solution_out %0d, status %0d",
                 resp.solution_out, resp.status);
        end else begin
          want = expected_answers.pop_front();
          if (resp.solution_out !== want.solution_out) begin
            error_count++;
            $error("solution_out: expected %0d, got %0d", want.solution_out,
                   resp.solution_out);
          end
          if (resp.status !== want.status) begin
            error_count++;
            $error("status: expected %0d, got %0d", want.status, resp.status);
          end
        end
      end
      if (req_valid && !req_stall) begin
        expected_answers.push_back(answer_request(req));
      end
    end
    pending_count = expected_answers.size();
  end

endmodule

>>> test/jacobi_poisson_1d_sweeps_top_tb.sv
// Testbench top of the Jacobi sweep block: drives transactions and registers, gives the verdict.
`timescale 1ns / 100ps
module jacobi_poisson_1d_sweeps_top_tb;
  import jps_pkg::*;

  localparam int MAX_POINTS = 1024;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] MAX_Q824 = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_Q824 = 32'sh8000_0000;

  logic                 clk;
  logic                 rst = 1'b1;
  req_t                 req = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  resp_t                resp;
  logic                 resp_valid;
  logic                 resp_stall = 1'b0;
  logic                 cfg_wen = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  int                   check_errors;
  int                   answers_pending;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   usable_limit = 100;
  bit                   point_written [0:MAX_POINTS];

  jacobi_poisson_1d_sweeps_top #(.MAX_INTERVALS(MAX_POINTS)) u_dut (
    .clk(clk), .rst(rst),
    .req(req), .req_valid(req_valid), .req_stall(req_stall),
    .resp(resp), .resp_valid(resp_valid), .resp_stall(resp_stall),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  jacobi_sweep_checker #(.MAX_INTERVALS(MAX_POINTS)) u_checker (
    .clk(clk), .rst(rst),
    .req(req), .req_valid(req_valid), .req_stall(req_stall),
    .resp(resp), .resp_valid(resp_valid), .resp_stall(resp_stall),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(check_errors), .pending_count(answers_pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    resp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] rand_q824();
    logic [DATA_W-1:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0: return r;
      1: return ($urandom_range(1) != 0) ? MAX_Q824 : MIN_Q824;
      default: return {{7{r[24]}}, r[24:0]};
    endcase
  endfunction

  function automatic req_t make_req(input logic [REQ_W-1:0] kind, input int idx,
                                    input logic signed [DATA_W-1:0] u,
                                    input logic signed [DATA_W-1:0] f);
    req_t r;
    r.req_type = kind;
    r.point_index = idx[IDX_W-1:0];
    r.solution_in = u;
    r.source_in = f;
    return r;
  endfunction

  task automatic send_item(input req_t item);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_all_answers();
    req_valid <= 1'b0;
    @(negedge clk);
    while (answers_pending != 0) @(negedge clk);
  endtask

  task automatic program_mesh(input logic [IDX_W-1:0] n, input logic [SWEEP_W-1:0] sweeps,
                              input logic [DATA_W-1:0] h2);
    wait_all_answers();
    cfg_wen <= 1'b1;
    cfg_index <= REG_INTERVAL_COUNT;
    cfg_data <= {{(DATA_W-IDX_W){1'b0}}, n};
    @(negedge clk);
    cfg_index <= REG_SWEEP_COUNT;
    cfg_data <= {{(DATA_W-SWEEP_W){1'b0}}, sweeps};
    @(negedge clk);
    cfg_index <= REG_STEP_SQUARED;
    cfg_data <= h2;
    @(negedge clk);
    cfg_wen <= 1'b0;
    usable_limit = (n > MAX_POINTS) ? MAX_POINTS : int'(n);
  endtask

  task automatic write_point(input int idx, input logic signed [DATA_W-1:0] u,
                             input logic signed [DATA_W-1:0] f);
    if (idx <= usable_limit) point_written[idx] = 1'b1;
    send_item(make_req(REQ_WRITE, idx, u, f));
  endtask

  task automatic read_point(input int idx);
    send_item(make_req(REQ_READ, idx, rand_q824(), rand_q824()));
  endtask

  task automatic start_run();
    send_item(make_req(REQ_RUN, $urandom_range(2047), rand_q824(), rand_q824()));
  endtask

  // Fill any unwritten point of the mesh, touch a few more, run, then read some back.
  task automatic relax_sequence(inout int sent);
    int k;
    for (int i = 0; i <= usable_limit; i++) begin
      if (!point_written[i]) begin
        write_point(i, rand_q824(), rand_q824());
        sent++;
      end
    end
    k = $urandom_range(3);
    repeat (k) begin
      write_point($urandom_range(usable_limit), rand_q824(), rand_q824());
      sent++;
    end
    start_run();
    sent++;
    k = $urandom_range(1, 4);
    repeat (k) begin
      read_point($urandom_range(usable_limit));
      sent++;
    end
  endtask

  task automatic run_phase(input logic [IDX_W-1:0] n, input logic [SWEEP_W-1:0] sweeps,
                           input logic [DATA_W-1:0] h2, input int budget);
    int sent;
    int pick;
    int idx;
    program_mesh(n, sweeps, h2);
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        relax_sequence(sent);
      end else if (pick < 68) begin
        idx = $urandom_range(usable_limit);
        if (!point_written[idx]) idx = $urandom_range(2047, usable_limit + 1);
        read_point(idx);
        sent++;
      end else if (pick < 80) begin
        write_point($urandom_range(usable_limit), rand_q824(), rand_q824());
        sent++;
      end else if (pick < 90) begin
        idx = $urandom_range(2047, usable_limit + 1);
        if ($urandom_range(1) != 0) begin
          write_point(idx, rand_q824(), rand_q824());
        end else begin
          read_point(idx);
        end
        sent++;
      end else if (pick < 95) begin
        send_item(make_req(REQ_UNUSED, $urandom_range(2047), rand_q824(), rand_q824()));
      end else begin
        wait_all_answers();
      end
    end
  endtask

  initial begin
    send_idle_pct = 36;
    recv_stall_pct = 59;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    program_mesh(11'd4, 16'd3, 32'hFFFF_FFFF);
    write_point(0, MAX_Q824, MIN_Q824);
    write_point(1, MIN_Q824, MAX_Q824);
    write_point(2, -32'sd1, MAX_Q824);
    write_point(3, MAX_Q824, MAX_Q824);
    write_point(4, MIN_Q824, MIN_Q824);
    start_run();
    for (int i = 0; i <= 4; i++) read_point(i);
    write_point(5, MAX_Q824, MAX_Q824);
    read_point(5);
    send_item(make_req(REQ_UNUSED, 2047, -32'sd1, -32'sd1));

    // A mesh above the limit still allows every point up to the limit.
    program_mesh(11'd2047, 16'd1, 32'h8000_0000);
    write_point(1024, MIN_Q824, MAX_Q824);
    read_point(1024);
    read_point(1025);
    read_point(2047);
    start_run();

    program_mesh(11'd1, 16'd5, 32'h8000_0000);
    start_run();
    read_point(1);
    read_point(2);

    program_mesh(11'd0, 16'd5, 32'h8000_0000);
    start_run();
    read_point(0);

    program_mesh(11'd4, 16'd0, 32'd429497);
    start_run();
    read_point(2);

    program_mesh(11'd2, 16'd65535, 32'd0);
    start_run();
    read_point(1);

    run_phase(INTERVAL_COUNT_RESET, SWEEP_COUNT_RESET, STEP_SQUARED_RESET, 90);
    run_phase(11'd8, 16'd1, 32'hFFFF_FFFF, 90);

    send_idle_pct = 59;
    recv_stall_pct = 36;
    run_phase(11'd3, 16'd2, 32'h8000_0000, 90);
    run_phase(11'd16, 16'd7, $urandom, 90);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_phase(11'd5, 16'd0, $urandom, 50);
    run_phase(11'd40, 16'd1, 32'd1, 40);

    wait_all_answers();
    repeat (20) @(negedge clk);
    if (check_errors == 0 && answers_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
